// ----- sv/tod_pkg.sv -----
package tod_pkg;

  // Direction codes
  localparam logic [2:0] DIR_DOWN  = 3'd0;
  localparam logic [2:0] DIR_RIGHT = 3'd1;
  localparam logic [2:0] DIR_UP    = 3'd2;
  localparam logic [2:0] DIR_LEFT  = 3'd3;
  localparam logic [2:0] DIR_NONE  = 3'd4;

  // Item opcodes
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_FORCE  = 2'd1;
  localparam logic [1:0] OP_CYCLE  = 2'd2;

  // Config register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_MAG  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STABLE   = 2'd2;

  // Field widths
  localparam int DIR_W      = 3;
  localparam int STRENGTH_W = 16;
  localparam int MIN_MAG_W  = 15;
  localparam int THR_W      = 2 * MIN_MAG_W;
  localparam int COUNT_W    = 4;
  localparam int GRAV_W     = 17;

  // Register reset values and limits
  localparam logic [STRENGTH_W-1:0] STRENGTH_RESET = 16'd5243;
  localparam logic [STRENGTH_W-1:0] STRENGTH_MAX   = 16'd32768;
  localparam logic [THR_W-1:0]      THR_RESET      = 30'd4194304; // 2048 squared
  localparam logic [COUNT_W-1:0]    STABLE_RESET   = 4'd5;

  // Live configuration
  typedef struct packed {
    logic [STRENGTH_W-1:0] strength;
    logic [THR_W-1:0]      thr_sq;
    logic [COUNT_W-1:0]    stable_needed;
  } cfg_t;

  // Per-item control carried past the squaring stage
  typedef struct packed {
    logic [1:0]       opcode;
    logic [DIR_W-1:0] forced;
    logic             y_dom;
    logic             x_pos;
    logic             y_pos;
  } ctl_t;

endpackage

// ----- sv/tod_in_if.sv -----
interface tod_in_if import tod_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic [1:0]                    opcode;
  logic signed [SAMPLE_BITS-1:0] accel_x;
  logic signed [SAMPLE_BITS-1:0] accel_y;
  logic signed [SAMPLE_BITS-1:0] accel_z;
  logic [DIR_W-1:0]              forced_direction;

  modport source(output valid, opcode, accel_x, accel_y, accel_z, forced_direction,
                 input ready);
  modport sink(input valid, opcode, accel_x, accel_y, accel_z, forced_direction,
               output ready);
endinterface

// ----- sv/tod_out_if.sv -----
interface tod_out_if import tod_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [DIR_W-1:0]         direction;
  logic signed [GRAV_W-1:0] grav_x;
  logic signed [GRAV_W-1:0] grav_y;

  modport source(output valid, direction, grav_x, grav_y, input ready);
  modport sink(input valid, direction, grav_x, grav_y, output ready);
endinterface

// ----- sv/tod_cfg_if.sv -----
interface tod_cfg_if import tod_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- sv/tod_cfg.sv -----
module tod_cfg import tod_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr,
  input  logic [CFG_IDX_W-1:0]  index,
  input  logic [CFG_DATA_W-1:0] data,
  output cfg_t                  cfg
);

  logic [MIN_MAG_W-1:0] min_mag;

  assign min_mag = data[MIN_MAG_W-1:0];

  // Config registers; threshold is kept squared
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.strength      <= STRENGTH_RESET;
      cfg.thr_sq        <= THR_RESET;
      cfg.stable_needed <= STABLE_RESET;
    end else if (wr) begin
      case (index)
        CFG_STRENGTH: begin
          cfg.strength <= (data[STRENGTH_W-1:0] > STRENGTH_MAX) ? STRENGTH_MAX
                                                                : data[STRENGTH_W-1:0];
        end
        CFG_MIN_MAG: begin
          cfg.thr_sq <= THR_W'(min_mag) * THR_W'(min_mag);
        end
        CFG_STABLE: begin
          cfg.stable_needed <= data[COUNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- sv/tod_square.sv -----
module tod_square import tod_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          load,
  input  logic [1:0]                    opcode,
  input  logic [DIR_W-1:0]              forced,
  input  logic signed [SAMPLE_BITS-1:0] accel_x,
  input  logic signed [SAMPLE_BITS-1:0] accel_y,
  input  logic signed [SAMPLE_BITS-1:0] accel_z,
  output ctl_t                          ctl,
  output logic [2*SAMPLE_BITS-1:0]      sq_x,
  output logic [2*SAMPLE_BITS-1:0]      sq_y,
  output logic [2*SAMPLE_BITS-1:0]      sq_z
);

  localparam int SQ_W = 2 * SAMPLE_BITS;

  logic [SAMPLE_BITS-1:0] abs_x;
  logic [SAMPLE_BITS-1:0] abs_y;
  logic [SAMPLE_BITS-1:0] abs_z;

  // Magnitudes; the most negative code maps to 2^(SAMPLE_BITS-1)
  assign abs_x = accel_x[SAMPLE_BITS-1] ? (~accel_x + 1'b1) : accel_x;
  assign abs_y = accel_y[SAMPLE_BITS-1] ? (~accel_y + 1'b1) : accel_y;
  assign abs_z = accel_z[SAMPLE_BITS-1] ? (~accel_z + 1'b1) : accel_z;

  // Squares and axis decisions, registered
  always_ff @(posedge clk) begin
    if (load) begin
      sq_x       <= SQ_W'(abs_x) * SQ_W'(abs_x);
      sq_y       <= SQ_W'(abs_y) * SQ_W'(abs_y);
      sq_z       <= SQ_W'(abs_z) * SQ_W'(abs_z);
      ctl.opcode <= opcode;
      ctl.forced <= forced;
      ctl.y_dom  <= abs_y > abs_x;
      ctl.x_pos  <= !accel_x[SAMPLE_BITS-1] && (accel_x != '0);
      ctl.y_pos  <= !accel_y[SAMPLE_BITS-1] && (accel_y != '0);
    end
  end

endmodule

// ----- sv/tod_track.sv -----
module tod_track import tod_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  cfg_t                        cfg,
  input  ctl_t                        ctl,
  input  logic [2*SAMPLE_BITS-1:0]    sq_x,
  input  logic [2*SAMPLE_BITS-1:0]    sq_y,
  input  logic [2*SAMPLE_BITS-1:0]    sq_z,
  output logic [DIR_W-1:0]            direction,
  output logic signed [GRAV_W-1:0]    grav_x,
  output logic signed [GRAV_W-1:0]    grav_y
);

  localparam int SUM_W = 2 * SAMPLE_BITS + 2;
  localparam int CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;

  logic [DIR_W-1:0]   current_dir;
  logic [DIR_W-1:0]   current_dir_next;
  logic [DIR_W-1:0]   candidate;
  logic [DIR_W-1:0]   candidate_next;
  logic [COUNT_W-1:0] stable_count;
  logic [COUNT_W-1:0] stable_count_next;

  logic [CMP_W-1:0]        sum_sq;
  logic [DIR_W-1:0]        sample_dir;
  logic signed [GRAV_W-1:0] pos_s;
  logic signed [GRAV_W-1:0] neg_s;
  logic signed [GRAV_W-1:0] grav_x_next;
  logic signed [GRAV_W-1:0] grav_y_next;

  // Magnitude test and dominant-axis classification
  assign sum_sq = CMP_W'(sq_x) + CMP_W'(sq_y) + CMP_W'(sq_z);

  always_comb begin
    if (sum_sq < CMP_W'(cfg.thr_sq)) begin
      sample_dir = DIR_NONE;
    end else if (ctl.y_dom) begin
      sample_dir = ctl.y_pos ? DIR_DOWN : DIR_UP;
    end else begin
      sample_dir = ctl.x_pos ? DIR_RIGHT : DIR_LEFT;
    end
  end

  // Debounce, force and cycle
  always_comb begin
    current_dir_next  = current_dir;
    candidate_next    = candidate;
    stable_count_next = stable_count;
    case (ctl.opcode)
      OP_SAMPLE: begin
        if (sample_dir == candidate) begin
          stable_count_next = stable_count + 4'd1;
        end else begin
          stable_count_next = 4'd1;
          candidate_next    = sample_dir;
        end
        if (stable_count_next >= cfg.stable_needed) begin
          current_dir_next  = sample_dir;
          stable_count_next = '0;
        end
      end
      OP_FORCE: begin
        if (ctl.forced <= DIR_NONE) begin
          current_dir_next = ctl.forced;
        end
      end
      OP_CYCLE: begin
        current_dir_next = (current_dir == DIR_NONE) ? DIR_DOWN : current_dir + 3'd1;
      end
      default: begin
      end
    endcase
  end

  // Gravity vector along the new direction
  assign pos_s = GRAV_W'(cfg.strength);
  assign neg_s = -pos_s;

  always_comb begin
    grav_x_next = '0;
    grav_y_next = '0;
    case (current_dir_next)
      DIR_DOWN:  grav_y_next = pos_s;
      DIR_UP:    grav_y_next = neg_s;
      DIR_RIGHT: grav_x_next = pos_s;
      DIR_LEFT:  grav_x_next = neg_s;
      default: begin
      end
    endcase
  end

  // Tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      current_dir  <= DIR_DOWN;
      candidate    <= DIR_DOWN;
      stable_count <= '0;
    end else if (load) begin
      current_dir  <= current_dir_next;
      candidate    <= candidate_next;
      stable_count <= stable_count_next;
    end
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (load) begin
      direction <= current_dir_next;
      grav_x    <= grav_x_next;
      grav_y    <= grav_y_next;
    end
  end

endmodule

// ----- sv/tilt_orientation_debouncer.sv -----
// Tilt orientation debouncer.
// in:  one word per accelerometer sample or command (opcode 0 sample,
//      1 force direction, 2 step direction); valid/ready.
// out: one word per input word: current direction (down, right, up, left,
//      none) and a gravity vector of the configured strength along it.
// cfg: register writes by index (0 strength, 1 minimum magnitude,
//      2 stable count), ready whenever rst is low; write only while the
//      block is idle.
// Three register stages: input word, squares, result. An accepted word
// moves from the input word register through squares into the result,
// and one word can enter every cycle unless out stalls. Updating state
// in the last stage lets consecutive samples follow without a gap.
// When out is stalled, words back up stage by stage and in.ready drops
// once all three stages hold a word.
// Reset (synchronous, rst high) empties the pipeline, holds in.ready and
// cfg.ready low, sets the direction, candidate and run count to
// down/down/0 and loads the default registers (strength 5243,
// magnitude 2048, stable count 5).
module tilt_orientation_debouncer import tod_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input logic    clk,
  input logic    rst,
  tod_in_if.sink in,
  tod_out_if.source out,
  tod_cfg_if.sink cfg
);

  localparam int SQ_W = 2 * SAMPLE_BITS;

  cfg_t cfg_regs;

  logic                          s1_valid;
  logic                          s1_valid_next;
  logic [1:0]                    s1_opcode;
  logic [DIR_W-1:0]              s1_forced;
  logic signed [SAMPLE_BITS-1:0] s1_x;
  logic signed [SAMPLE_BITS-1:0] s1_y;
  logic signed [SAMPLE_BITS-1:0] s1_z;

  logic             s2_valid;
  logic             s2_valid_next;
  ctl_t             s2_ctl;
  logic [SQ_W-1:0]  s2_sq_x;
  logic [SQ_W-1:0]  s2_sq_y;
  logic [SQ_W-1:0]  s2_sq_z;

  logic out_valid;
  logic out_valid_next;
  logic load_out;
  logic load_s2;
  logic load_s1;

  // Pipeline flow control
  assign load_out = s2_valid && (!out_valid || out.ready);
  assign load_s2  = s1_valid && (!s2_valid || load_out);
  assign in.ready = !rst && (!s1_valid || load_s2);
  assign load_s1  = in.valid && in.ready;

  assign s1_valid_next  = load_s1 ? 1'b1 : (load_s2 ? 1'b0 : s1_valid);
  assign s2_valid_next  = load_s2 ? 1'b1 : (load_out ? 1'b0 : s2_valid);
  assign out_valid_next = load_out ? 1'b1 : (out.ready ? 1'b0 : out_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= s1_valid_next;
      s2_valid  <= s2_valid_next;
      out_valid <= out_valid_next;
    end
  end

  // Input word register
  always_ff @(posedge clk) begin
    if (load_s1) begin
      s1_opcode <= in.opcode;
      s1_forced <= in.forced_direction;
      s1_x      <= in.accel_x;
      s1_y      <= in.accel_y;
      s1_z      <= in.accel_z;
    end
  end

  assign out.valid = out_valid;
  assign cfg.ready = !rst;

  tod_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wr    (cfg.valid),
    .index (cfg.index),
    .data  (cfg.data),
    .cfg   (cfg_regs)
  );

  tod_square #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_square (
    .clk     (clk),
    .load    (load_s2),
    .opcode  (s1_opcode),
    .forced  (s1_forced),
    .accel_x (s1_x),
    .accel_y (s1_y),
    .accel_z (s1_z),
    .ctl     (s2_ctl),
    .sq_x    (s2_sq_x),
    .sq_y    (s2_sq_y),
    .sq_z    (s2_sq_z)
  );

  tod_track #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_track (
    .clk       (clk),
    .rst       (rst),
    .load      (load_out),
    .cfg       (cfg_regs),
    .ctl       (s2_ctl),
    .sq_x      (s2_sq_x),
    .sq_y      (s2_sq_y),
    .sq_z      (s2_sq_z),
    .direction (out.direction),
    .grav_x    (out.grav_x),
    .grav_y    (out.grav_y)
  );

  // Checks
  a_dir_code: assert property (@(posedge clk) disable iff (rst)
    out.valid |-> (out.direction <= DIR_NONE))
    else $error("direction code out of range");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (out.valid && out.direction == DIR_NONE) |-> (out.grav_x == '0 && out.grav_y == '0))
    else $error("gravity nonzero for no direction");

  a_down_strength: assert property (@(posedge clk) disable iff (rst)
    (out.valid && out.direction == DIR_DOWN)
      |-> (out.grav_x == '0 && out.grav_y == GRAV_W'(cfg_regs.strength)))
    else $error("down gravity does not match strength");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (in.valid && in.ready) |=> s1_valid)
    else $error("accepted word not held in input stage");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import tod_pkg::*;

  // Codes the package leaves out: the spare opcode, a config index past the
  // last register, and a direction code above none
  localparam logic [1:0]           OP_NOP      = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;
  localparam logic [DIR_W-1:0]     DIR_INVALID = 3'd7;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int          HOLD_CYCLES = 400;
  localparam int          PHASE_WORDS = 135;

  typedef struct packed {
    logic [DIR_W-1:0]         dir;
    logic signed [GRAV_W-1:0] gx;
    logic signed [GRAV_W-1:0] gy;
  } heading_t;

  typedef struct {
    logic [1:0]        op;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic [DIR_W-1:0]  fdir;
    bit                typed;
    heading_t          want;
  } tilt_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tod_in_if #(.SAMPLE_BITS(16)) in_ch ();
  tod_out_if out_ch ();
  tod_cfg_if cfg_ch ();

  tilt_orientation_debouncer #(.SAMPLE_BITS(16)) DUT (
    .clk (clk),
    .rst (rst),
    .in  (in_ch),
    .out (out_ch),
    .cfg (cfg_ch)
  );

  always #4 clk = ~clk;

  // Mirror of the block's registers and debounce state
  logic [STRENGTH_W-1:0] grav_str;
  logic [MIN_MAG_W-1:0]  mag_floor;
  logic [COUNT_W-1:0]    runs_needed;
  logic [DIR_W-1:0]      cur_dir;
  logic [DIR_W-1:0]      cand_dir;
  logic [COUNT_W-1:0]    run_len;

  heading_t    heading_q[$];
  tilt_row_t   script[$];
  int          errors = 0;
  int unsigned cycles = 0;
  bit          hold_req = 1'b0;
  bit          send_idle = 1'b1;
  bit          recv_idle = 1'b1;

  // Random sample runs: direction being held and words left in the run
  logic [DIR_W-1:0] run_dir = DIR_DOWN;
  int               run_left = 0;

  // Next heading after one word; updates the mirrored state
  function automatic heading_t track_heading(logic [1:0] op, logic signed [15:0] x,
                                             logic signed [15:0] y, logic signed [15:0] z,
                                             logic [DIR_W-1:0] f);
    heading_t         r;
    longint           mx, my, mz, thr;
    logic [DIR_W-1:0] cls;
    logic [GRAV_W-1:0] s;
    mx = longint'(x);
    my = longint'(y);
    mz = longint'(z);
    case (op)
      OP_SAMPLE: begin
        thr = longint'(mag_floor) * longint'(mag_floor);
        if (mx * mx + my * my + mz * mz < thr) cls = DIR_NONE;
        else if ((my < 0 ? -my : my) > (mx < 0 ? -mx : mx)) cls = (my > 0) ? DIR_DOWN : DIR_UP;
        else cls = (mx > 0) ? DIR_RIGHT : DIR_LEFT;
        if (cls == cand_dir) begin
          run_len = run_len + 1'b1;
        end else begin
          run_len = 4'd1;
          cand_dir = cls;
        end
        if (run_len >= runs_needed) begin
          cur_dir = cls;
          run_len = '0;
        end
      end
      OP_FORCE: if (f <= DIR_NONE) cur_dir = f;
      OP_CYCLE: cur_dir = (cur_dir == DIR_NONE) ? DIR_DOWN : cur_dir + 1'b1;
      default: ;
    endcase
    s = {1'b0, grav_str};
    r.dir = cur_dir;
    r.gx = '0;
    r.gy = '0;
    case (cur_dir)
      DIR_DOWN:  r.gy = s;
      DIR_UP:    r.gy = -s;
      DIR_RIGHT: r.gx = s;
      DIR_LEFT:  r.gx = -s;
      default: ;
    endcase
    return r;
  endfunction

  function automatic tilt_row_t mk(logic [1:0] op, int x, int y, int z, logic [DIR_W-1:0] f,
                                   bit typed = 1'b0, logic [DIR_W-1:0] d = DIR_DOWN,
                                   int gx = 0, int gy = 0);
    tilt_row_t r;
    r.op = op;
    r.ax = 16'(x);
    r.ay = 16'(y);
    r.az = 16'(z);
    r.fdir = f;
    r.typed = typed;
    r.want.dir = d;
    r.want.gx = GRAV_W'(gx);
    r.want.gy = GRAV_W'(gy);
    return r;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // Random word: mostly runs of samples leaning one way, plus commands and noise
  function automatic tilt_row_t next_random_row();
    tilt_row_t r;
    int        pick, dom, side, lim;
    r = mk(OP_SAMPLE, $urandom(), $urandom(), $urandom(), DIR_W'($urandom()));
    if (run_left == 0) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        r.op = OP_FORCE;
        if ($urandom_range(1)) r.fdir = DIR_W'($urandom_range(4));
        return r;
      end
      if (pick < 14) begin
        r.op = OP_CYCLE;
        return r;
      end
      if (pick < 16) begin
        r.op = OP_NOP;
        return r;
      end
      if (pick < 26) return r;
      run_dir = DIR_W'($urandom_range(4));
      run_left = $urandom_range(runs_needed + 2, 1);
    end
    run_left--;
    dom = $urandom_range(1) ? $urandom_range(32767, 16384) : $urandom_range(32767, 1);
    side = $urandom_range(dom - 1, 0);
    if ($urandom_range(1)) side = -side;
    case (run_dir)
      DIR_DOWN: begin
        r.ay = 16'(dom);
        r.ax = 16'(side);
      end
      DIR_UP: begin
        r.ay = 16'((dom == 32767 && $urandom_range(3) == 0) ? -32768 : -dom);
        r.ax = 16'(side);
      end
      DIR_RIGHT: begin
        r.ax = 16'(dom);
        r.ay = 16'(side);
      end
      DIR_LEFT: begin
        // flat x and y now and then: falls to left
        if ($urandom_range(7) == 0) begin
          r.ax = '0;
          r.ay = '0;
        end else begin
          r.ax = 16'(-dom);
          r.ay = 16'(side);
        end
      end
      default: begin
        // keep the sum of squares under the threshold
        lim = int'(mag_floor) / 2;
        r.ax = 16'($urandom_range(2 * lim, 0) - lim);
        r.ay = 16'($urandom_range(2 * lim, 0) - lim);
        r.az = 16'($urandom_range(2 * lim, 0) - lim);
      end
    endcase
    return r;
  endfunction

  // Offer one word, wait for it to be taken, queue its expected result
  task automatic send_item(tilt_row_t r, int gap);
    heading_t next_hd;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= r.op;
    in_ch.accel_x <= r.ax;
    in_ch.accel_y <= r.ay;
    in_ch.accel_z <= r.az;
    in_ch.forced_direction <= r.fdir;
    do @(posedge clk); while (!in_ch.ready);
    next_hd = track_heading(r.op, r.ax, r.ay, r.az, r.fdir);
    heading_q.push_back(r.typed ? r.want : next_hd);
  endtask

  // Leaves cfg valid high; the caller lowers it after the last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_STRENGTH: grav_str = (data > STRENGTH_MAX) ? STRENGTH_MAX : data;
      CFG_MIN_MAG:  mag_floor = data[MIN_MAG_W-1:0];
      CFG_STABLE:   runs_needed = data[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [15:0] s, logic [15:0] m, logic [15:0] n, bit poke_unused);
    write_reg(CFG_STRENGTH, s);
    write_reg(CFG_MIN_MAG, m);
    write_reg(CFG_STABLE, n);
    if (poke_unused) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom()));
    cfg_ch.valid <= 1'b0;
  endtask

  // Stop sending and let every outstanding word come back
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (heading_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tilt_orientation_debouncer: mismatch");
      $finish;
    end
  end

  // Result checker
  always @(posedge clk) begin : check_words
    heading_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (heading_q.size() == 0) begin
        $error("unexpected word: direction %0d grav_x %0d grav_y %0d",
               out_ch.direction, out_ch.grav_x, out_ch.grav_y);
        errors++;
      end else begin
        want = heading_q.pop_front();
        if (out_ch.direction !== want.dir) begin
          $error("direction: expected %0d, got %0d", want.dir, out_ch.direction);
          errors++;
        end
        if (out_ch.grav_x !== want.gx) begin
          $error("grav_x: expected %0d, got %0d", want.gx, out_ch.grav_x);
          errors++;
        end
        if (out_ch.grav_y !== want.gy) begin
          $error("grav_y: expected %0d, got %0d", want.gy, out_ch.grav_y);
          errors++;
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (recv_idle && $urandom_range(3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Sender and register writes
  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_SAMPLE;
    in_ch.accel_x = '0;
    in_ch.accel_y = '0;
    in_ch.accel_z = '0;
    in_ch.forced_direction = DIR_DOWN;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_STRENGTH;
    cfg_ch.data = '0;
    grav_str = STRENGTH_RESET;
    mag_floor = 15'd2048;
    runs_needed = STABLE_RESET;
    cur_dir = DIR_DOWN;
    cand_dir = DIR_DOWN;
    run_len = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words under the reset registers
    script.push_back(mk(OP_NOP, 0, 0, 0, DIR_DOWN, 1, DIR_DOWN, 0, 5243));
    script.push_back(mk(OP_FORCE, 0, 0, 0, DIR_RIGHT, 1, DIR_RIGHT, 5243, 0));
    script.push_back(mk(OP_FORCE, 0, 0, 0, DIR_INVALID, 1, DIR_RIGHT, 5243, 0));
    script.push_back(mk(OP_FORCE, 0, 0, 0, DIR_NONE, 1, DIR_NONE, 0, 0));
    script.push_back(mk(OP_CYCLE, 0, 0, 0, DIR_DOWN, 1, DIR_DOWN, 0, 5243));
    script.push_back(mk(OP_CYCLE, 0, 0, 0, DIR_DOWN, 1, DIR_RIGHT, 5243, 0));
    script.push_back(mk(OP_FORCE, 0, 0, 0, DIR_LEFT, 1, DIR_LEFT, -5243, 0));
    script.push_back(mk(OP_FORCE, 0, 0, 0, DIR_UP, 1, DIR_UP, 0, -5243));
    // flat x and y with gravity on z: left, confirmed on the fifth
    repeat (5) script.push_back(mk(OP_SAMPLE, 0, 0, 16384, DIR_DOWN));
    // equal |x| and |y|: x wins
    script.push_back(mk(OP_SAMPLE, -32768, -32768, -32768, DIR_DOWN));
    script.push_back(mk(OP_SAMPLE, 32767, 0, 0, DIR_INVALID));
    script.push_back(mk(OP_SAMPLE, 0, 32767, 0, DIR_DOWN));
    script.push_back(mk(OP_SAMPLE, 0, -32768, 0, DIR_DOWN));
    script.push_back(mk(OP_SAMPLE, 1, -1, 1, DIR_DOWN));
    // right at the threshold and just under it
    script.push_back(mk(OP_SAMPLE, 2048, 0, 0, DIR_DOWN));
    script.push_back(mk(OP_SAMPLE, 2047, 0, 0, DIR_DOWN));
    script.push_back(mk(OP_SAMPLE, -2048, 0, 0, DIR_DOWN));
    script.push_back(mk(OP_NOP, -1, -1, -1, DIR_INVALID));
    foreach (script[i]) send_item(script[i], pick_gap());
    settle();

    // Random phases, each under its own register setting
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_regs(16'hFFFF, 16'd0, 16'd0, 1);
        1: set_regs(16'd32768, 16'h7FFF, 16'd15, 0);
        2: set_regs(16'd0, 16'd1, 16'd1, 1);
        3: set_regs(16'd32769, 16'h8800, 16'hFFF3, 0);
        default: set_regs(16'($urandom()), {1'($urandom_range(1)), 15'($urandom_range(6000))},
                          16'($urandom()), ph == 6);
      endcase
      send_idle = (ph != 5);
      recv_idle = (ph != 5);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        // receiver stops for a long stretch while words keep coming
        if (ph == 1 && k == 30) hold_req = 1'b1;
        // sender waits for everything outstanding to drain
        if (ph == 3 && k == 60) settle();
        send_item(next_random_row(), send_idle ? pick_gap() : 0);
      end
      settle();
    end

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tilt_orientation_debouncer: match");
    end else begin
      $display("tilt_orientation_debouncer: mismatch");
    end
    $finish;
  end

endmodule
